@@ rtl/core/plm_pkg.sv @@
// Shared types, constants and helpers for the per-node lighting metrics block.
// Used by plm_calc and per_node_lighting_metrics; depends on nothing.
package plm_pkg;

  // Node table geometry. The node address port is fixed at seven bits.
  localparam int NODE_COUNT = 128;
  localparam int NODE_W     = 7;

  // Reset value of the flicker scale register: 1.0 in unsigned Q16.16.
  localparam logic [31:0] FLICKER_SCALE_RST = 32'h0001_0000;

  // The flicker term is added only once the count before the sample exceeds this.
  localparam logic [31:0] FLICKER_MIN_COUNT = 32'd3;

  // One stored entry of the node table.
  typedef struct packed {
    logic [31:0] prev_time;
    logic [31:0] prev_lux;
    logic [31:0] older_lux;
    logic [31:0] prev_ref;
    logic [63:0] energy;
    logic [63:0] flicker;
    logic [63:0] shortfall;
    logic [31:0] count;
  } plm_rec_t;

  localparam int REC_W = $bits(plm_rec_t);

  // One accepted input sample, held for the whole update.
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [31:0]       time_stamp;
    logic [31:0]       lux;
    logic [7:0]        pwm;
    logic              ref_present;
    logic [31:0]       ref_lux;
  } plm_sample_t;

  // Stage enables from the sequencer to the datapath.
  typedef struct packed {
    logic diff_en;
    logic mul_en;
  } plm_ctrl_t;

  // Unsigned 64-bit add that sticks at the maximum on overflow.
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

@@ rtl/core/plm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; holds the per-node table of the lighting metrics block.
module plm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/plm_calc.sv @@
// Update datapath: difference stage, multiply stage and saturating accumulate.
// Depends on plm_pkg for the record, sample and control types.
module plm_calc (
  input  logic                 clk,
  input  plm_pkg::plm_ctrl_t   ctrl,
  input  plm_pkg::plm_sample_t sample,
  input  logic                 seen,
  input  plm_pkg::plm_rec_t    rd_rec,
  input  logic [31:0]          scale,
  output plm_pkg::plm_rec_t    wr_rec
);

  // Difference stage registers.
  plm_pkg::plm_rec_t d_rec;
  logic              d_seen;
  logic [31:0]       d_ref;
  logic [31:0]       d_short;
  logic [31:0]       d_dt;
  logic              d_rev;
  logic [32:0]       d_swing;

  // Multiply stage registers.
  logic [39:0] m_energy;
  logic [64:0] m_flick;

  logic [31:0] ref_sel;
  logic [31:0] l1;
  logic [31:0] l2;
  logic [31:0] l3;
  logic [31:0] diff32;
  logic [31:0] diff21;
  logic        rev;

  // Reference choice, lux swing and reversal detection.
  always_comb begin
    if (sample.ref_present) begin
      ref_sel = sample.ref_lux;
    end else if (seen) begin
      ref_sel = rd_rec.prev_ref;
    end else begin
      ref_sel = 32'd0;
    end
    l1     = sample.lux;
    l2     = rd_rec.prev_lux;
    l3     = rd_rec.older_lux;
    diff32 = (l3 > l2) ? (l3 - l2) : (l2 - l3);
    diff21 = (l2 > l1) ? (l2 - l1) : (l1 - l2);
    rev    = (rd_rec.count > plm_pkg::FLICKER_MIN_COUNT) &&
             (((l3 < l2) && (l2 > l1)) || ((l3 > l2) && (l2 < l1)));
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      d_rec   <= rd_rec;
      d_seen  <= seen;
      d_ref   <= ref_sel;
      d_short <= (ref_sel > sample.lux) ? (ref_sel - sample.lux) : 32'd0;
      d_dt    <= sample.time_stamp - rd_rec.prev_time;
      d_rev   <= rev;
      d_swing <= {1'b0, diff32} + {1'b0, diff21};
    end
  end

  // Energy and flicker products.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      m_energy <= 40'(sample.pwm) * 40'(d_dt);
      m_flick  <= 65'(d_swing) * 65'(scale);
    end
  end

  // New entry: first sample starts the sums, later samples accumulate.
  always_comb begin
    wr_rec           = d_rec;
    wr_rec.prev_time = sample.time_stamp;
    wr_rec.prev_lux  = sample.lux;
    wr_rec.prev_ref  = d_ref;
    if (!d_seen) begin
      wr_rec.older_lux = sample.lux;
      wr_rec.energy    = 64'd0;
      wr_rec.flicker   = 64'd0;
      wr_rec.shortfall = {32'd0, d_short};
      wr_rec.count     = 32'd1;
    end else begin
      wr_rec.older_lux = d_rec.prev_lux;
      wr_rec.energy    = plm_pkg::sat_add64(d_rec.energy, {24'd0, m_energy});
      wr_rec.flicker   = d_rev ? plm_pkg::sat_add64(d_rec.flicker, {15'd0, m_flick[64:16]})
                               : d_rec.flicker;
      wr_rec.shortfall = plm_pkg::sat_add64(d_rec.shortfall, {32'd0, d_short});
      wr_rec.count     = (&d_rec.count) ? d_rec.count : (d_rec.count + 32'd1);
    end
  end

endmodule

@@ rtl/core/per_node_lighting_metrics.sv @@
// Per-node lighting metrics: top level with sequencer, seen flags and output register.
// Depends on plm_pkg, plm_ram and plm_calc.
//
// Usage:
//   Samples arrive on the input channel (in_valid/in_ready) and each one
//   produces exactly one result beat on the output channel (out_valid/out_ready)
//   carrying the node's updated count and energy, flicker and shortfall sums.
//   The flicker scale register is written over its own channel
//   (cfg_valid/cfg_ready/cfg_data); cfg_ready is always high.
//   Each sample is a read-modify-write of one entry of the node table RAM:
//   the read issues on the accepting edge, then the difference, multiply and
//   accumulate states follow, and the accumulate state writes the entry back.
//   A new sample is taken only once the last one has been written back. One
//   sample is in flight at a time, so the write-back always lands before the
//   next read.
//   The result sits in an output register; a new sample is accepted while it
//   waits, but the write-back stalls while the register is still full.
//   Reset clears the seen flags, so every node starts fresh, and sets the
//   flicker scale to 1.0 (Q16.16). The RAM itself is not cleared.
module per_node_lighting_metrics (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [31:0]                 cfg_data,
  // Sample input channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [plm_pkg::NODE_W-1:0]  node_addr,
  input  logic [31:0]                 time_stamp,
  input  logic [31:0]                 measured_lux,
  input  logic [7:0]                  pwm_duty,
  input  logic                        ref_present,
  input  logic [31:0]                 ref_lux,
  // Result output channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [plm_pkg::NODE_W-1:0]  out_node,
  output logic [31:0]                 sample_total,
  output logic [63:0]                 energy_total,
  output logic [63:0]                 flicker_total,
  output logic [63:0]                 shortfall_total
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIFF = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_ACC  = 4'b1000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [31:0]                    scale;
  logic [plm_pkg::NODE_COUNT-1:0] seen;
  plm_pkg::plm_sample_t           sample;
  plm_pkg::plm_ctrl_t             ctrl;
  plm_pkg::plm_rec_t              rd_rec;
  plm_pkg::plm_rec_t              wr_rec;
  logic [plm_pkg::REC_W-1:0]      rd_data;
  logic                           in_fire;
  logic                           commit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign commit    = (state == ST_ACC) && (!out_valid || out_ready);
  assign rd_rec    = plm_pkg::plm_rec_t'(rd_data);

  // Flicker scale register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= plm_pkg::FLICKER_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      scale <= cfg_data;
    end
  end

  // Sequencer for one read-modify-write per sample.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_DIFF;
      end
      ST_DIFF: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC: begin
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ctrl.diff_en = (state == ST_DIFF);
  assign ctrl.mul_en  = (state == ST_MUL);

  // Hold the accepted sample for the whole update.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample.node        <= node_addr;
      sample.time_stamp  <= time_stamp;
      sample.lux         <= measured_lux;
      sample.pwm         <= pwm_duty;
      sample.ref_present <= ref_present;
      sample.ref_lux     <= ref_lux;
    end
  end

  // Seen flags: a node's entry is meaningful only once its flag is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (commit) begin
      seen[sample.node] <= 1'b1;
    end
  end

  // Node table; read on the accepting edge, written back at commit.
  plm_ram #(
    .WIDTH (plm_pkg::REC_W),
    .DEPTH (plm_pkg::NODE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (commit),
    .waddr (sample.node),
    .wdata (wr_rec),
    .raddr (node_addr),
    .rdata (rd_data)
  );

  plm_calc u_calc (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (sample),
    .seen   (seen[sample.node]),
    .rd_rec (rd_rec),
    .scale  (scale),
    .wr_rec (wr_rec)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_node        <= sample.node;
      sample_total    <= wr_rec.count;
      energy_total    <= wr_rec.energy;
      flicker_total   <= wr_rec.flicker;
      shortfall_total <= wr_rec.shortfall;
    end
  end

endmodule

@@ tb/per_node_lighting_metrics_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for per_node_lighting_metrics: a per-node predictor checks every
// result beat. Depends on plm_pkg and the per_node_lighting_metrics RTL.
module per_node_lighting_metrics_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_HOLD  = 300;
  localparam int PHASE_ITEMS    = 360;
  localparam int MAX_REPORTS    = 30;

  // Totals of one node as reported on the result channel.
  typedef struct packed {
    logic [plm_pkg::NODE_W-1:0] node;
    logic [31:0]                count;
    logic [63:0]                energy;
    logic [63:0]                flicker;
    logic [63:0]                shortfall;
  } node_totals_t;

  // Predicts the node table and checks result beats against the predicted totals.
  class lux_metrics_board;
    bit                seen       [plm_pkg::NODE_COUNT];
    bit [31:0]         last_time  [plm_pkg::NODE_COUNT];
    bit [31:0]         last_lux   [plm_pkg::NODE_COUNT];
    bit [31:0]         older_lux  [plm_pkg::NODE_COUNT];
    bit [31:0]         last_ref   [plm_pkg::NODE_COUNT];
    bit [31:0]         count      [plm_pkg::NODE_COUNT];
    bit [63:0]         energy     [plm_pkg::NODE_COUNT];
    bit [63:0]         flicker    [plm_pkg::NODE_COUNT];
    bit [63:0]         shortfall  [plm_pkg::NODE_COUNT];
    bit [31:0]         scale;
    node_totals_t      pending_totals[$];
    int                errors;
    int                samples;
    int                checked;
    int                reversals;

    function new();
      scale = plm_pkg::FLICKER_SCALE_RST;
    endfunction

    function bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
      bit [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t ns: mismatch: %s", $time, msg);
      end
    endtask

    // Update the node's entry with one accepted sample and queue its totals.
    function void note_sample(plm_pkg::plm_sample_t s);
      node_totals_t r;
      bit [31:0]    ref_used;
      bit [63:0]    short_amt;
      bit [31:0]    dt;
      bit [32:0]    swing;
      bit [64:0]    prod;
      bit [31:0]    l3;
      bit [31:0]    l2;
      int           n;
      n = s.node;
      samples++;
      ref_used = s.ref_present ? s.ref_lux : (seen[n] ? last_ref[n] : 32'd0);
      short_amt = (ref_used > s.lux) ? 64'(ref_used - s.lux) : 64'd0;
      if (!seen[n]) begin
        seen[n]      = 1'b1;
        energy[n]    = '0;
        flicker[n]   = '0;
        shortfall[n] = short_amt;
        count[n]     = 32'd1;
        older_lux[n] = s.lux;
      end else begin
        dt = s.time_stamp - last_time[n];
        energy[n] = sat_sum(energy[n], 64'(s.pwm) * 64'(dt));
        // Flicker counts only a strict reversal of the lux direction, once warmed up.
        l3 = older_lux[n];
        l2 = last_lux[n];
        if (count[n] > plm_pkg::FLICKER_MIN_COUNT &&
            ((l3 < l2 && l2 > s.lux) || (l3 > l2 && l2 < s.lux))) begin
          swing = ((l3 > l2) ? 33'(l3 - l2) : 33'(l2 - l3)) +
                  ((l2 > s.lux) ? 33'(l2 - s.lux) : 33'(s.lux - l2));
          prod = 65'(swing) * 65'(scale);
          flicker[n] = sat_sum(flicker[n], 64'(prod >> 16));
          reversals++;
        end
        shortfall[n] = sat_sum(shortfall[n], short_amt);
        if (count[n] != 32'hFFFF_FFFF) begin
          count[n]++;
        end
        older_lux[n] = l2;
      end
      last_time[n] = s.time_stamp;
      last_lux[n]  = s.lux;
      last_ref[n]  = ref_used;
      r.node      = s.node;
      r.count     = count[n];
      r.energy    = energy[n];
      r.flicker   = flicker[n];
      r.shortfall = shortfall[n];
      pending_totals.insert(pending_totals.size(), r);
    endfunction

    // Compare one result beat with the oldest predicted totals.
    task check_result(node_totals_t got);
      node_totals_t want;
      if (pending_totals.size() == 0) begin
        report($sformatf("result beat for node %0d with no sample outstanding", got.node));
      end else begin
        want = pending_totals.pop_front();
        checked++;
        if (got.node != want.node)
          report($sformatf("out_node %0d, predicted %0d", got.node, want.node));
        if (got.count != want.count)
          report($sformatf("node %0d sample_total %0d, predicted %0d",
                           want.node, got.count, want.count));
        if (got.energy != want.energy)
          report($sformatf("node %0d energy_total %h, predicted %h",
                           want.node, got.energy, want.energy));
        if (got.flicker != want.flicker)
          report($sformatf("node %0d flicker_total %h, predicted %h",
                           want.node, got.flicker, want.flicker));
        if (got.shortfall != want.shortfall)
          report($sformatf("node %0d shortfall_total %h, predicted %h",
                           want.node, got.shortfall, want.shortfall));
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [31:0]                cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [plm_pkg::NODE_W-1:0] node_addr;
  logic [31:0]                time_stamp;
  logic [31:0]                measured_lux;
  logic [7:0]                 pwm_duty;
  logic                       ref_present;
  logic [31:0]                ref_lux;
  logic                       out_valid;
  logic                       out_ready;
  logic [plm_pkg::NODE_W-1:0] out_node;
  logic [31:0]                sample_total;
  logic [63:0]                energy_total;
  logic [63:0]                flicker_total;
  logic [63:0]                shortfall_total;

  lux_metrics_board board = new();
  bit               hold_req = 1'b0;
  bit               no_gaps = 1'b0;
  int               idle_cycles = 0;
  int               scale_writes = 0;
  bit [31:0]        tick = 32'd0;

  per_node_lighting_metrics dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .node_addr       (node_addr),
    .time_stamp      (time_stamp),
    .measured_lux    (measured_lux),
    .pwm_duty        (pwm_duty),
    .ref_present     (ref_present),
    .ref_lux         (ref_lux),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_node        (out_node),
    .sample_total    (sample_total),
    .energy_total    (energy_total),
    .flicker_total   (flicker_total),
    .shortfall_total (shortfall_total)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Observe every beat at the edge that moves it.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        board.scale = cfg_data;
      end
      if (in_valid && in_ready) begin
        board.note_sample(plm_pkg::plm_sample_t'{node_addr, time_stamp, measured_lux,
                                                 pwm_duty, ref_present, ref_lux});
      end
      if (out_valid && out_ready) begin
        board.check_result(node_totals_t'{out_node, sample_total, energy_total,
                                          flicker_total, shortfall_total});
      end
    end
  end

  // End the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, board.pending_totals.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off when the sender asks for it.
  initial begin
    int n;
    int r;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 30);
      end else if (r < 92) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        n = $urandom_range(15, 50);
      end
      do begin
        @(posedge clk);
        n--;
      end while (n > 0 && !hold_req);
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function plm_pkg::plm_sample_t mk(int node, bit [31:0] t, bit [31:0] lux, bit [7:0] pwm,
                                    bit rp, bit [31:0] ref_val);
    return plm_pkg::plm_sample_t'{node[plm_pkg::NODE_W-1:0], t, lux, pwm, rp, ref_val};
  endfunction

  // Offer one sample, after an optional gap, and hold it until accepted.
  task send_sample(plm_pkg::plm_sample_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    node_addr    <= s.node;
    time_stamp   <= s.time_stamp;
    measured_lux <= s.lux;
    pwm_duty     <= s.pwm;
    ref_present  <= s.ref_present;
    ref_lux      <= s.ref_lux;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let every outstanding result drain before touching the register.
  task wait_drained();
    while (board.pending_totals.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_scale(bit [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_writes++;
  endtask

  // One random phase: a few busy nodes with stepped lux levels, plus noise.
  task run_random_phase(bit [31:0] lux_step, bit with_pressure);
    int                   pool [6];
    int                   r;
    int                   node;
    bit [31:0]            t;
    bit [31:0]            lux;
    plm_pkg::plm_sample_t s;
    foreach (pool[i]) pool[i] = $urandom_range(0, plm_pkg::NODE_COUNT - 1);
    if (with_pressure) begin
      hold_req = 1'b1;
      no_gaps  = 1'b1;
    end
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (with_pressure && i == 40) no_gaps = 1'b0;
      // A stretch with no sender idling every so often.
      if (!with_pressure && i % 100 == 50) no_gaps = 1'b1;
      if (!with_pressure && i % 100 == 80) no_gaps = 1'b0;
      node = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)]
                                          : $urandom_range(0, plm_pkg::NODE_COUNT - 1);
      tick = tick + $urandom_range(1, 1000);
      t = ($urandom_range(0, 99) < 85) ? tick : $urandom;
      r = $urandom_range(0, 99);
      if (r < 70) lux = lux_step * $urandom_range(0, 3);
      else if (r < 85) lux = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      else lux = $urandom;
      s = mk(node, t, lux, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             ($urandom_range(0, 1) ? $urandom : lux_step * $urandom_range(0, 3)));
      send_sample(s);
    end
    in_valid <= 1'b0;
  endtask

  // Stimulus.
  initial begin
    bit [31:0] scales [5];
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    node_addr    <= '0;
    time_stamp   <= '0;
    measured_lux <= '0;
    pwm_duty     <= '0;
    ref_present  <= 1'b0;
    ref_lux      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples at the reset scale.
    // Node 5: new node without a reference, a time stamp that wraps, then a lux
    // sequence that reverses before and after the warm-up, including a swing
    // wider than 32 bits and flat stretches that do not count.
    send_sample(mk(5, 32'hFFFF_FFF0, 32'd100, 8'd255, 1'b0, 32'hDEAD_BEEF));
    send_sample(mk(5, 32'h0000_0010, 32'd200, 8'd255, 1'b1, 32'hFFFF_FFFF));
    send_sample(mk(5, 32'h0000_0100, 32'd100, 8'd0,   1'b0, 32'd0));
    send_sample(mk(5, 32'h0000_0200, 32'd200, 8'd128, 1'b1, 32'd0));
    send_sample(mk(5, 32'h0000_0300, 32'd100, 8'd1,   1'b1, 32'd150));
    send_sample(mk(5, 32'h0000_0400, 32'hFFFF_FFFF, 8'd2, 1'b0, 32'd0));
    send_sample(mk(5, 32'h0000_0500, 32'd0,   8'd3,   1'b0, 32'd0));
    send_sample(mk(5, 32'h0000_0600, 32'd0,   8'd4,   1'b0, 32'd0));
    send_sample(mk(5, 32'h0000_0700, 32'hFFFF_FFFF, 8'd5, 1'b1, 32'hFFFF_FFFF));
    // Node 127: largest shortfall, largest time step at full duty.
    send_sample(mk(127, 32'd0, 32'd0, 8'd255, 1'b1, 32'hFFFF_FFFF));
    send_sample(mk(127, 32'hFFFF_FFFF, 32'd0, 8'd255, 1'b0, 32'd0));
    send_sample(mk(127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1'b0, 32'd0));
    // Node 0: reference below the lux, zero time step, then a late reversal.
    send_sample(mk(0, 32'd1000, 32'd10, 8'd0,   1'b1, 32'd5));
    send_sample(mk(0, 32'd1000, 32'd20, 8'd255, 1'b0, 32'd0));
    send_sample(mk(0, 32'd2000, 32'd30, 8'd17,  1'b1, 32'd35));
    send_sample(mk(0, 32'd3000, 32'd40, 8'd17,  1'b0, 32'd0));
    send_sample(mk(0, 32'd4000, 32'd50, 8'd17,  1'b0, 32'd0));
    send_sample(mk(0, 32'd5000, 32'd40, 8'd17,  1'b0, 32'd0));
    send_sample(mk(0, 32'd6000, 32'd60, 8'd17,  1'b1, 32'h7FFF_FFFF));
    in_valid <= 1'b0;

    // Random phases, each at its own scale, the extremes among them.
    scales[0] = 32'd0;
    scales[1] = 32'hFFFF_FFFF;
    scales[2] = 32'd1;
    scales[3] = $urandom;
    scales[4] = plm_pkg::FLICKER_SCALE_RST;
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_scale(scales[p]);
      run_random_phase((p % 2 == 0) ? 32'd1000 : 32'h5555_5555, p == 1);
    end

    wait_drained();
    $display("Checked %0d result beats for %0d samples, %0d of them lux reversals;",
             board.checked, board.samples, board.reversals);
    $display("%0d flicker scale settings were applied between phases.", scale_writes);
    if (board.errors == 0 && board.pending_totals.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
